[hdl/hzm_pkg.sv]
`default_nettype none

package hzm_pkg;

    localparam int NUM_ENTITIES_DEF = 256;

    localparam int COORD_W = 24;
    localparam int LEN_W   = 23;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 8;
    localparam int COUNT_W = 9;

    // register indexes on the configuration port
    localparam logic [2:0] CFG_CENTER_X    = 3'd0;
    localparam logic [2:0] CFG_CENTER_Y    = 3'd1;
    localparam logic [2:0] CFG_CENTER_Z    = 3'd2;
    localparam logic [2:0] CFG_RADIUS      = 3'd3;
    localparam logic [2:0] CFG_HALF_HEIGHT = 3'd4;
    localparam logic [2:0] CFG_BAND        = 3'd5;

    typedef enum logic [1:0] {
        CMD_UPDATE = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_TEST   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        MB_NONE     = 2'd0,
        MB_APPROACH = 2'd1,
        MB_INSIDE   = 2'd2,
        MB_LEAVING  = 2'd3
    } member_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_ACC,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic [1:0]                cmd;
        logic [IDX_W-1:0]          entity_index;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
    } in_word_t;

    typedef struct packed {
        logic       is_inside;
        logic [1:0] membership;
        logic       area_empty;
    } out_word_t;

endpackage

`default_nettype wire

[hdl/hzm_ram.sv]
`default_nettype none

module hzm_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hdl/hysteresis_zone_membership_core.sv]
`default_nettype none

// Zone membership tracker for one cylindrical area with hysteresis bands.
// Sequence: a start accepted in idle steps through MUL0, MUL1, MUL2, ACC and DECIDE, and
// the result strobe (done) is registered from DECIDE. A new command is taken only once the
// sequence through the two shared 24x24 squarers (three coordinate squares and three
// threshold squares) is over and busy is low. Reset: asynchronous, active low; the table is
// then swept to none, one entry a cycle, with busy high. Results cannot be stalled by the receiver.
module hysteresis_zone_membership_core #(
    parameter int NUM_ENTITIES = hzm_pkg::NUM_ENTITIES_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire hzm_pkg::in_word_t        request,
    output logic                          done,
    output hzm_pkg::out_word_t            result,
    input  wire logic                     cfg_we,
    input  wire logic [2:0]               cfg_index,
    input  wire logic [hzm_pkg::CFG_W-1:0] cfg_data
);

    import hzm_pkg::*;

    localparam int AW = $clog2(NUM_ENTITIES);
    localparam int MAG_W = COORD_W;
    localparam int SQ_W = 2 * MAG_W;
    localparam int D2_W = SQ_W + 2;

    state_t state_reg, state_next;

    // configuration
    logic signed [COORD_W-1:0] center_x_reg, center_y_reg, center_z_reg;
    logic [LEN_W-1:0]          radius_reg, half_height_reg, band_reg;

    // item registers
    logic [1:0]       cmd_reg;
    logic [AW-1:0]    idx_reg;
    logic             valid_reg;
    logic [MAG_W-1:0] mag_x_reg, mag_y_reg, mag_z_reg;
    member_t          cur_reg;

    logic [SQ_W-1:0]  prod_a_reg, prod_b_reg;
    logic [D2_W-1:0]  d2_reg;
    logic [SQ_W-3:0]  r2_reg, enter2_reg;
    logic [SQ_W-1:0]  leave2_reg;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [AW-1:0]      clr_addr_reg;

    logic      done_reg;
    out_word_t result_reg, result_next;

    // memory port
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [1:0]    mem_wdata, mem_rdata;

    // datapath helpers
    logic [MAG_W-1:0] mul_a_op, mul_b_op;
    logic [MAG_W-1:0] mag_x_in, mag_y_in, mag_z_in;
    logic [MAG_W-1:0] leave;
    logic [LEN_W-1:0] enter;
    logic             core_possible;
    logic             accept;
    member_t          ns;
    logic             write_entry;
    logic             in_zone;

    function automatic logic [MAG_W-1:0] abs_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] d;
        logic [COORD_W:0]        m;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        m = d[COORD_W] ? (~d + 1'b1) : d;
        return m[MAG_W-1:0];
    endfunction

    function automatic logic counted(input member_t s);
        return s inside {MB_INSIDE, MB_LEAVING};
    endfunction

    hzm_ram #(
        .WIDTH(2),
        .DEPTH(NUM_ENTITIES)
    ) u_table (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = result_reg;

    assign mag_x_in = abs_diff(request.pos_x, center_x_reg);
    assign mag_y_in = abs_diff(request.pos_y, center_y_reg);
    assign mag_z_in = abs_diff(request.pos_z, center_z_reg);

    assign core_possible = band_reg <= radius_reg;
    assign leave = MAG_W'(radius_reg) + MAG_W'(band_reg);
    assign enter = core_possible ? (radius_reg - band_reg) : '0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == AW'(NUM_ENTITIES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_MUL0;
                end
            end
            ST_MUL0:   state_next = ST_MUL1;
            ST_MUL1:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_ACC;
            ST_ACC:    state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    // decision on the finished squares
    always_comb
    begin
        ns          = MB_NONE;
        write_entry = 1'b0;
        in_zone     = 1'b0;
        if (cmd_reg == CMD_UPDATE && valid_reg)
        begin
            write_entry = 1'b1;
            if (mag_z_reg > MAG_W'(half_height_reg) || d2_reg > D2_W'(leave2_reg))
            begin
                ns = MB_NONE;
            end
            else if (d2_reg > D2_W'(r2_reg))
            begin
                ns = counted(cur_reg) ? MB_LEAVING : MB_NONE;
            end
            else if (!core_possible || d2_reg > D2_W'(enter2_reg))
            begin
                ns = counted(cur_reg) ? MB_INSIDE : MB_APPROACH;
            end
            else
            begin
                ns = MB_INSIDE;
            end
            in_zone = counted(ns);
        end
        else if (cmd_reg == CMD_REMOVE && valid_reg)
        begin
            write_entry = 1'b1;
            ns          = MB_NONE;
            in_zone     = counted(cur_reg);
        end
        else if (cmd_reg == CMD_TEST)
        begin
            in_zone = d2_reg <= D2_W'(r2_reg);
        end

        count_next = count_reg;
        if (write_entry)
        begin
            count_next = count_reg - COUNT_W'(counted(cur_reg)) + COUNT_W'(counted(ns));
        end

        result_next.is_inside  = in_zone;
        result_next.membership = write_entry ? ns : cur_reg;
        result_next.area_empty = (count_next == '0);
    end

    // outputs of the sequencer
    always_comb
    begin
        busy      = 1'b1;
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = MB_NONE;
        mem_raddr = idx_reg;
        mul_a_op  = mag_x_reg;
        mul_b_op  = MAG_W'(radius_reg);
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
            end
            ST_IDLE:
            begin
                busy      = 1'b0;
                mem_raddr = AW'(request.entity_index);
            end
            ST_MUL0:
            begin
                mul_a_op = mag_x_reg;
                mul_b_op = MAG_W'(radius_reg);
            end
            ST_MUL1:
            begin
                mul_a_op = mag_y_reg;
                mul_b_op = leave;
            end
            ST_MUL2:
            begin
                mul_a_op = mag_z_reg;
                mul_b_op = MAG_W'(enter);
            end
            ST_DECIDE:
            begin
                mem_we    = write_entry;
                mem_wdata = ns;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            count_reg       <= '0;
            done_reg        <= 1'b0;
            center_x_reg    <= '0;
            center_y_reg    <= '0;
            center_z_reg    <= '0;
            radius_reg      <= '0;
            half_height_reg <= '0;
            band_reg        <= LEN_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_DECIDE);
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (state_reg == ST_DECIDE)
            begin
                count_reg <= count_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CENTER_X:    center_x_reg    <= cfg_data;
                    CFG_CENTER_Y:    center_y_reg    <= cfg_data;
                    CFG_CENTER_Z:    center_z_reg    <= cfg_data;
                    CFG_RADIUS:      radius_reg      <= cfg_data[LEN_W-1:0];
                    CFG_HALF_HEIGHT: half_height_reg <= cfg_data[LEN_W-1:0];
                    CFG_BAND:        band_reg        <= cfg_data[LEN_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    // datapath words
    always_ff @(posedge clk)
    begin
        prod_a_reg <= mul_a_op * mul_a_op;
        prod_b_reg <= mul_b_op * mul_b_op;
        if (accept)
        begin
            cmd_reg   <= request.cmd;
            idx_reg   <= AW'(request.entity_index);
            valid_reg <= 32'(request.entity_index) < NUM_ENTITIES;
            mag_x_reg <= mag_x_in;
            mag_y_reg <= mag_y_in;
            mag_z_reg <= mag_z_in;
        end
        case (state_reg)
            ST_MUL0:
            begin
                cur_reg <= valid_reg ? member_t'(mem_rdata) : MB_NONE;
            end
            ST_MUL1:
            begin
                d2_reg <= D2_W'(prod_a_reg);
                r2_reg <= prod_b_reg[SQ_W-3:0];
            end
            ST_MUL2:
            begin
                d2_reg     <= d2_reg + D2_W'(prod_a_reg);
                leave2_reg <= prod_b_reg;
            end
            ST_ACC:
            begin
                d2_reg     <= d2_reg + D2_W'(prod_a_reg);
                enter2_reg <= prod_b_reg[SQ_W-3:0];
            end
            ST_DECIDE:
            begin
                result_reg <= result_next;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

[test/tb_hysteresis_zone_membership_core.sv]
module tb_hysteresis_zone_membership_core;
    import hzm_pkg::*;

    localparam logic [1:0] CMD_SPARE   = 2'd3;
    localparam logic [2:0] CFG_SPARE_6 = 3'd6;
    localparam logic [2:0] CFG_SPARE_7 = 3'd7;

    localparam longint COORD_MAX = 8388607;
    localparam longint COORD_MIN = -8388608;
    localparam longint LEN_MAX   = 8388607;

    localparam int SETTLE_CYCLES = 10;
    localparam int TAIL_CYCLES   = 20;
    localparam int PRINT_LIMIT   = 40;
    localparam int PHASES        = 8;
    localparam int PHASE_WORDS   = 55;

    typedef enum logic [1:0] {
        JOB_WORD,
        JOB_REG,
        JOB_SETTLE
    } job_kind_t;

    typedef struct packed {
        job_kind_t        kind;
        in_word_t         word;
        logic [2:0]       reg_idx;
        logic [CFG_W-1:0] reg_val;
    } job_t;

    typedef enum int {
        RING_BEYOND,
        RING_LEAVE_EDGE,
        RING_OUTER,
        RING_RIM,
        RING_INNER,
        RING_CORE_EDGE,
        RING_CENTRE,
        RING_ANY
    } ring_t;

    typedef enum int {
        LIFT_FLAT,
        LIFT_JITTER,
        LIFT_TOP,
        LIFT_BOTTOM,
        LIFT_ABOVE,
        LIFT_BELOW
    } lift_t;

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    logic             busy;
    in_word_t         request   = '0;
    logic             done;
    out_word_t        result;
    logic             cfg_we    = 1'b0;
    logic [2:0]       cfg_index = '0;
    logic [CFG_W-1:0] cfg_data  = '0;

    hysteresis_zone_membership_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // own copy of the area and the membership table
    logic signed [COORD_W-1:0] area_cx;
    logic signed [COORD_W-1:0] area_cy;
    logic signed [COORD_W-1:0] area_cz;
    logic [LEN_W-1:0]          area_radius;
    logic [LEN_W-1:0]          area_half_height;
    logic [LEN_W-1:0]          area_band;
    member_t                   zone_state [NUM_ENTITIES_DEF];
    logic [COUNT_W-1:0]        counted_members;

    out_word_t expected_words [$];
    out_word_t oldest_word;
    job_t      pending_jobs [$];
    job_t      head_job;
    int        mismatches = 0;

    // area as the stimulus generator expects it to be programmed
    longint plan_cx;
    longint plan_cy;
    longint plan_cz;
    longint plan_radius;
    longint plan_half;
    longint plan_band;

    logic     nxt_start;
    in_word_t nxt_word;
    logic     nxt_we;
    int       gap_left;
    int       settle_count;
    bit       burst;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic flag_mismatch(input string what);
        if (mismatches < PRINT_LIMIT)
            $display("%0t mismatch: %s", $time, what);
        mismatches++;
    endtask

    function automatic logic is_counted(member_t s);
        return s == MB_INSIDE || s == MB_LEAVING;
    endfunction

    task automatic set_zone_state(input int unsigned idx, input member_t s);
        if (is_counted(zone_state[idx]))
            counted_members--;
        if (is_counted(s))
            counted_members++;
        zone_state[idx] = s;
    endtask

    task automatic apply_register(input logic [2:0] idx, input logic [CFG_W-1:0] val);
        case (idx)
            CFG_CENTER_X:    area_cx = val;
            CFG_CENTER_Y:    area_cy = val;
            CFG_CENTER_Z:    area_cz = val;
            CFG_RADIUS:      area_radius = val[LEN_W-1:0];
            CFG_HALF_HEIGHT: area_half_height = val[LEN_W-1:0];
            CFG_BAND:        area_band = val[LEN_W-1:0];
            default:         ;
        endcase
    endtask

    task automatic predict_membership(input in_word_t w);
        longint      dx;
        longint      dy;
        longint      dz;
        longint      d2;
        longint      r2;
        longint      leave;
        longint      enter;
        longint      up;
        longint      down;
        longint      pz;
        logic        valid;
        logic        core_ok;
        logic        hit;
        member_t     cur;
        member_t     nxt;
        int unsigned idx;
        out_word_t   want;
        idx    = w.entity_index;
        valid  = idx < NUM_ENTITIES_DEF;
        cur    = valid ? zone_state[idx] : MB_NONE;
        hit    = 1'b0;
        pz     = longint'($signed(w.pos_z));
        dx     = longint'($signed(w.pos_x)) - longint'(area_cx);
        dy     = longint'($signed(w.pos_y)) - longint'(area_cy);
        dz     = pz - longint'(area_cz);
        d2     = dx * dx + dy * dy + dz * dz;
        r2     = longint'(area_radius) * longint'(area_radius);
        if (w.cmd == CMD_UPDATE && valid)
        begin
            leave   = longint'(area_radius) + longint'(area_band);
            core_ok = area_band <= area_radius;
            enter   = core_ok ? longint'(area_radius) - longint'(area_band) : 0;
            up      = longint'(area_cz) + longint'(area_half_height);
            down    = longint'(area_cz) - longint'(area_half_height);
            if (pz > up || pz < down || d2 > leave * leave)
                nxt = MB_NONE;
            else if (d2 > r2)
                nxt = is_counted(cur) ? MB_LEAVING : MB_NONE;
            else if (!core_ok || d2 > enter * enter)
                nxt = is_counted(cur) ? MB_INSIDE : MB_APPROACH;
            else
                nxt = MB_INSIDE;
            set_zone_state(idx, nxt);
            cur = nxt;
            hit = is_counted(nxt);
        end
        else if (w.cmd == CMD_REMOVE && valid)
        begin
            hit = is_counted(cur);
            set_zone_state(idx, MB_NONE);
            cur = MB_NONE;
        end
        else if (w.cmd == CMD_TEST)
        begin
            hit = d2 <= r2;
        end
        want.is_inside  = hit;
        want.membership = cur;
        want.area_empty = counted_members == 0;
        expected_words.push_back(want);
    endtask

    // driver: words, register writes and idle pauses, all in queue order
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            request   <= '0;
            cfg_we    <= 1'b0;
            cfg_index <= '0;
            cfg_data  <= '0;
            gap_left         = 0;
            settle_count     = 0;
            burst            = 1'b0;
            area_cx          = '0;
            area_cy          = '0;
            area_cz          = '0;
            area_radius      = '0;
            area_half_height = '0;
            area_band        = 1;
            counted_members  = '0;
            foreach (zone_state[i])
                zone_state[i] = MB_NONE;
        end
        else
        begin
            nxt_start = start;
            nxt_word  = request;
            nxt_we    = 1'b0;
            if (cfg_we)
                apply_register(cfg_index, cfg_data);
            if (start && !busy)
            begin
                predict_membership(request);
                nxt_start = 1'b0;
            end
            if (!nxt_start)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_jobs.size() != 0)
                begin
                    head_job = pending_jobs[0];
                    case (head_job.kind)
                        JOB_WORD:
                        begin
                            nxt_start = 1'b1;
                            nxt_word  = head_job.word;
                            pending_jobs.delete(0);
                            if ($urandom_range(0, 29) == 0)
                                burst = !burst;
                            gap_left = burst ? 0 : $urandom_range(0, 4);
                        end
                        JOB_REG:
                        begin
                            nxt_we = 1'b1;
                            cfg_index <= head_job.reg_idx;
                            cfg_data  <= head_job.reg_val;
                            pending_jobs.delete(0);
                        end
                        default:
                        begin
                            // idle means nothing owed and nothing in flight, for a while
                            if (!busy && !done && expected_words.size() == 0)
                            begin
                                if (settle_count == SETTLE_CYCLES)
                                begin
                                    settle_count = 0;
                                    pending_jobs.delete(0);
                                    burst = $urandom_range(0, 2) == 0;
                                end
                                else
                                begin
                                    settle_count++;
                                end
                            end
                            else
                            begin
                                settle_count = 0;
                            end
                        end
                    endcase
                end
            end
            start   <= nxt_start;
            request <= nxt_word;
            cfg_we  <= nxt_we;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_words.size() == 0)
            begin
                flag_mismatch($sformatf("result word %h with nothing outstanding", result));
            end
            else
            begin
                oldest_word = expected_words.pop_front();
                if (result.is_inside !== oldest_word.is_inside)
                    flag_mismatch($sformatf("is_inside %b, want %b",
                                            result.is_inside, oldest_word.is_inside));
                if (result.membership !== oldest_word.membership)
                    flag_mismatch($sformatf("membership %0d, want %0d",
                                            result.membership, oldest_word.membership));
                if (result.area_empty !== oldest_word.area_empty)
                    flag_mismatch($sformatf("area_empty %b, want %b",
                                            result.area_empty, oldest_word.area_empty));
            end
        end
    end

    task automatic push_settle();
        job_t j;
        j      = '0;
        j.kind = JOB_SETTLE;
        pending_jobs.push_back(j);
    endtask

    task automatic push_reg(input logic [2:0] idx, input logic [CFG_W-1:0] val);
        job_t j;
        j         = '0;
        j.kind    = JOB_REG;
        j.reg_idx = idx;
        j.reg_val = val;
        pending_jobs.push_back(j);
        case (idx)
            CFG_CENTER_X:    plan_cx = longint'($signed(val));
            CFG_CENTER_Y:    plan_cy = longint'($signed(val));
            CFG_CENTER_Z:    plan_cz = longint'($signed(val));
            CFG_RADIUS:      plan_radius = longint'(val[LEN_W-1:0]);
            CFG_HALF_HEIGHT: plan_half = longint'(val[LEN_W-1:0]);
            CFG_BAND:        plan_band = longint'(val[LEN_W-1:0]);
            default:         ;
        endcase
    endtask

    task automatic program_area(input logic [CFG_W-1:0] cx, input logic [CFG_W-1:0] cy,
                                input logic [CFG_W-1:0] cz, input logic [CFG_W-1:0] r,
                                input logic [CFG_W-1:0] hh, input logic [CFG_W-1:0] b);
        push_settle();
        push_reg(CFG_CENTER_X, cx);
        push_reg(CFG_CENTER_Y, cy);
        push_reg(CFG_CENTER_Z, cz);
        push_reg(CFG_RADIUS, r);
        push_reg(CFG_HALF_HEIGHT, hh);
        push_reg(CFG_BAND, b);
    endtask

    task automatic push_word(input logic [1:0] cmd, input logic [IDX_W-1:0] ent,
                             input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic [COORD_W-1:0] z);
        job_t j;
        j                   = '0;
        j.kind              = JOB_WORD;
        j.word.cmd          = cmd;
        j.word.entity_index = ent;
        j.word.pos_x        = x;
        j.word.pos_y        = y;
        j.word.pos_z        = z;
        pending_jobs.push_back(j);
    endtask

    function automatic longint fit_coord(longint centre, longint offset);
        longint v;
        v = centre + offset;
        if (v > COORD_MAX || v < COORD_MIN)
            v = centre - offset;
        if (v > COORD_MAX)
            v = COORD_MAX;
        if (v < COORD_MIN)
            v = COORD_MIN;
        return v;
    endfunction

    // position at a chosen distance along x (with a y jitter of up to 3 for RING_ANY), with a chosen height offset
    task automatic push_near_ring(input logic [1:0] cmd, input logic [IDX_W-1:0] ent,
                                  input ring_t ring, input lift_t lift);
        longint t;
        longint ox;
        longint oy;
        longint oz;
        longint px;
        longint py;
        longint pz;
        oy = 0;
        case (ring)
            RING_BEYOND:     t = plan_radius + plan_band + 1;
            RING_LEAVE_EDGE: t = plan_radius + plan_band;
            RING_OUTER:      t = plan_radius + 1;
            RING_RIM:        t = plan_radius;
            RING_INNER:      t = plan_radius - plan_band + 1;
            RING_CORE_EDGE:  t = plan_radius - plan_band;
            RING_CENTRE:     t = 0;
            default:
            begin
                t  = $urandom_range(0, 32'(plan_radius + 2 * plan_band + 2));
                oy = longint'($urandom_range(0, 6)) - 3;
            end
        endcase
        if (t < 0)
            t = 0;
        case (lift)
            LIFT_JITTER: oz = longint'($urandom_range(0, 6)) - 3;
            LIFT_TOP:    oz = plan_half;
            LIFT_BOTTOM: oz = -plan_half;
            LIFT_ABOVE:  oz = plan_half + 1;
            LIFT_BELOW:  oz = -plan_half - 1;
            default:     oz = 0;
        endcase
        ox = $urandom_range(0, 1) ? t : -t;
        px = fit_coord(plan_cx, ox);
        py = fit_coord(plan_cy, oy);
        pz = fit_coord(plan_cz, oz);
        push_word(cmd, ent, px[COORD_W-1:0], py[COORD_W-1:0], pz[COORD_W-1:0]);
    endtask

    function automatic logic [CFG_W-1:0] pick_centre();
        case ($urandom_range(0, 5))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            default: return 24'($urandom());
        endcase
    endfunction

    task automatic random_phase(input int n_words);
        longint           r;
        longint           b;
        longint           h;
        logic [IDX_W-1:0] pool [6];
        logic [IDX_W-1:0] ent;
        int               pick;
        int               lf;
        lift_t            lift;
        case ($urandom_range(0, 7))
            0:       r = 0;
            1:       r = LEN_MAX;
            2:       r = $urandom_range(1, 64);
            default: r = $urandom_range(64, 1 << 20);
        endcase
        case ($urandom_range(0, 7))
            0:       b = (r + 2 > LEN_MAX) ? LEN_MAX : r + $urandom_range(0, 2);
            1:       b = 0;
            2:       b = LEN_MAX;
            default: b = $urandom_range(1, 32'(r / 4 + 1));
        endcase
        case ($urandom_range(0, 7))
            0:       h = 0;
            1:       h = LEN_MAX;
            default: h = $urandom_range(0, 1 << 21);
        endcase
        // top bit of the length registers is don't-care
        program_area(pick_centre(), pick_centre(), pick_centre(),
                     {1'($urandom_range(0, 1)), r[LEN_W-1:0]},
                     {1'($urandom_range(0, 1)), h[LEN_W-1:0]},
                     {1'($urandom_range(0, 1)), b[LEN_W-1:0]});
        foreach (pool[i])
            pool[i] = 8'($urandom());
        for (int k = 0; k < n_words; k++)
        begin
            pick = $urandom_range(0, 99);
            ent  = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : pool[$urandom_range(0, 5)];
            lf   = $urandom_range(0, 15);
            lift = (lf < 10) ? LIFT_FLAT : lift_t'(lf - 10);
            if (pick < 12)
                push_word(2'($urandom_range(0, 3)), 8'($urandom()), 24'($urandom()),
                          24'($urandom()), 24'($urandom()));
            else if (pick < 20)
                push_near_ring(CMD_REMOVE, ent, ring_t'($urandom_range(0, 7)), lift);
            else if (pick < 30)
                push_near_ring(CMD_TEST, ent, ring_t'($urandom_range(0, 7)), lift);
            else if (pick < 32)
                push_near_ring(CMD_SPARE, ent, RING_ANY, lift);
            else
                push_near_ring(CMD_UPDATE, ent, ring_t'($urandom_range(0, 7)), lift);
            // now and then let everything drain mid-stream
            if (pick == 50)
                push_settle();
        end
    endtask

    initial
    begin
        // walk one entity through every membership state
        program_area(24'd1000, 24'(-2000), 24'd300, 24'd4096, 24'd2048, 24'd410);
        push_near_ring(CMD_UPDATE, 8'd5, RING_CENTRE, LIFT_FLAT);
        push_near_ring(CMD_UPDATE, 8'd5, RING_OUTER, LIFT_FLAT);
        push_near_ring(CMD_UPDATE, 8'd5, RING_RIM, LIFT_FLAT);
        push_near_ring(CMD_UPDATE, 8'd5, RING_LEAVE_EDGE, LIFT_FLAT);
        push_near_ring(CMD_UPDATE, 8'd5, RING_BEYOND, LIFT_FLAT);
        push_near_ring(CMD_UPDATE, 8'd5, RING_INNER, LIFT_FLAT);
        push_near_ring(CMD_UPDATE, 8'd5, RING_OUTER, LIFT_FLAT);
        push_near_ring(CMD_UPDATE, 8'd5, RING_INNER, LIFT_FLAT);
        push_near_ring(CMD_UPDATE, 8'd5, RING_CORE_EDGE, LIFT_FLAT);
        push_near_ring(CMD_UPDATE, 8'd5, RING_CENTRE, LIFT_ABOVE);
        push_near_ring(CMD_UPDATE, 8'd0, RING_CENTRE, LIFT_TOP);
        push_near_ring(CMD_UPDATE, 8'd255, RING_CENTRE, LIFT_BOTTOM);
        push_near_ring(CMD_UPDATE, 8'd0, RING_CENTRE, LIFT_BELOW);
        push_near_ring(CMD_UPDATE, 8'd0, RING_INNER, LIFT_FLAT);
        push_near_ring(CMD_SPARE, 8'd255, RING_BEYOND, LIFT_FLAT);
        // plain test ignores the height limits
        push_near_ring(CMD_TEST, 8'd7, RING_RIM, LIFT_ABOVE);
        push_near_ring(CMD_TEST, 8'd7, RING_OUTER, LIFT_FLAT);
        push_near_ring(CMD_REMOVE, 8'd255, RING_CENTRE, LIFT_FLAT);
        push_near_ring(CMD_REMOVE, 8'd255, RING_CENTRE, LIFT_FLAT);
        push_word(CMD_UPDATE, 8'd9, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
        push_word(CMD_TEST, 8'd9, 24'h800000, 24'h7FFFFF, 24'h800000);
        // band equal to radius: only the centre point is core
        program_area(24'd0, 24'd0, 24'd0, 24'd100, 24'd50, 24'd100);
        push_near_ring(CMD_UPDATE, 8'd3, RING_CENTRE, LIFT_FLAT);
        // band wider than radius: no core at all
        push_settle();
        push_reg(CFG_BAND, 24'd101);
        push_near_ring(CMD_UPDATE, 8'd4, RING_CENTRE, LIFT_FLAT);
        // extreme registers, plus writes to the unused indexes
        program_area(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        push_reg(CFG_SPARE_6, 24'hA5C3E1);
        push_reg(CFG_SPARE_7, 24'hFFFFFF);
        push_word(CMD_UPDATE, 8'd1, 24'h800000, 24'h7FFFFF, 24'h800000);
        push_near_ring(CMD_UPDATE, 8'd1, RING_RIM, LIFT_TOP);

        for (int p = 0; p < PHASES; p++)
            random_phase(PHASE_WORDS);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (pending_jobs.size() != 0 || start || done || expected_words.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("** hysteresis_zone_membership_core: PASSED **");
        else
            $display("** hysteresis_zone_membership_core: FAILED **");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("** hysteresis_zone_membership_core: FAILED **");
        $finish;
    end

endmodule
